// ----- rtl/set_assoc_lru_cache_tag_model_macros.svh -----
// Assertion macros shared by the cache tag model.
// Each macro is clocked by clk and is disabled while arst_n is low.
`ifndef SET_ASSOC_LRU_CACHE_TAG_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_MODEL_MACROS_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SALC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SALC_ASSERT(lbl, prop, msg)
`define SALC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/salc_pkg.sv -----
package salc_pkg;

	localparam int KIND_W = 2;
	localparam int ADDR_W = 32;
	localparam int TAG_W = 32;
	localparam int CNT_W = 32;
	localparam int SETF_W = 12;
	localparam int LAST_W = 4;
	localparam int SUM_W = 6;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int QPTR_W = 1;
	localparam int QDEPTH = 1 << QPTR_W;

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FETCH = 2'd3;

	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS = 2'd2;

	// One classified access waiting for the tag store.
	typedef struct packed {
		logic modify;
		logic [SETF_W-1:0] set;
		logic [TAG_W-1:0] tag;
		logic [LAST_W-1:0] last;
	} q_entry_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ----- rtl/salc_if.sv -----
interface salc_acc_if;
	import salc_pkg::*;
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] address;
	modport source(output valid, kind, address, input ready);
	modport sink(input valid, kind, address, output ready);
endinterface

interface salc_res_if;
	import salc_pkg::*;
	logic valid;
	logic ready;
	logic was_hit;
	logic was_eviction;
	logic extra_hit;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;
	logic [CNT_W-1:0] eviction_total;
	modport source(output valid, was_hit, was_eviction, extra_hit, hit_total, miss_total,
		eviction_total, input ready);
	modport sink(input valid, was_hit, was_eviction, extra_hit, hit_total, miss_total,
		eviction_total, output ready);
endinterface

// ----- rtl/salc_front.sv -----
module salc_front #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS = 8,
	parameter int ADDR_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [salc_pkg::PADDR_W-1:0] paddr,
	input logic [salc_pkg::PDATA_W-1:0] pwdata,
	output logic [salc_pkg::PDATA_W-1:0] prdata,
	salc_acc_if.sink acc,
	input logic q_full,
	output logic push,
	output salc_pkg::q_entry_t entry
);
	import salc_pkg::*;

	localparam int AW_EFF = ADDR_WIDTH < ADDR_W ? ADDR_WIDTH : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AW_EFF);

	logic [2:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_q;
	logic cfg_wr;
	logic [LAST_W-1:0] s_eff;
	logic [SUM_W-1:0] sb_sum;
	logic [LAST_W:0] e_eff;
	logic [ADDR_W-1:0] addr_eff;

	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd4;
			offset_bits_q <= 5'd4;
			ways_q <= 4'd8;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SET_BITS: set_bits_q <= pwdata[2:0];
				REG_OFFSET_BITS: offset_bits_q <= pwdata[4:0];
				REG_WAYS: ways_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SET_BITS: prdata = {{(PDATA_W-3){1'b0}}, set_bits_q};
			REG_OFFSET_BITS: prdata = {{(PDATA_W-5){1'b0}}, offset_bits_q};
			REG_WAYS: prdata = {{(PDATA_W-4){1'b0}}, ways_q};
			default: prdata = '0;
		endcase
	end

	// Address split; shifts past the address width give zero tag and set.
	always_comb begin
		s_eff = (32'(set_bits_q) > MAX_SET_BITS) ? LAST_W'(MAX_SET_BITS)
			: LAST_W'(set_bits_q);
		sb_sum = SUM_W'(s_eff) + SUM_W'(offset_bits_q);
		addr_eff = acc.address & ADDR_MASK;
		if (ways_q == 4'd0)
			e_eff = (LAST_W+1)'(1);
		else if (32'(ways_q) > WAYS)
			e_eff = (LAST_W+1)'(WAYS);
		else
			e_eff = (LAST_W+1)'(ways_q);
		entry.modify = (acc.kind == KIND_MODIFY);
		entry.tag = addr_eff >> sb_sum;
		entry.set = SETF_W'(addr_eff >> offset_bits_q) & ~({SETF_W{1'b1}} << s_eff);
		entry.last = LAST_W'(e_eff - 1'b1);
	end

	assign acc.ready = !q_full;
	assign push = acc.valid && !q_full && (acc.kind != KIND_FETCH);

endmodule

// ----- rtl/salc_queue.sv -----
module salc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input salc_pkg::q_entry_t push_entry,
	output logic full,
	input logic pop,
	output salc_pkg::q_entry_t head,
	output logic empty
);
	import salc_pkg::*;

	q_entry_t slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/salc_back.sv -----
`include "set_assoc_lru_cache_tag_model_macros.svh"

module salc_back #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS = 8
) (
	input logic clk,
	input logic arst_n,
	input salc_pkg::q_entry_t head,
	input logic empty,
	output logic pop,
	salc_res_if.source res
);
	import salc_pkg::*;

	localparam int SET_W = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam logic ST_READ = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	// One row per set: all tags, valid flags and the recency order.
	logic [WAYS-1:0][TAG_W-1:0] tag_mem [NUM_SETS];
	logic [WAYS-1:0] valid_mem [NUM_SETS];
	logic [WAYS-1:0][WAY_W-1:0] ord_mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_valid_q;

	logic state_q;
	q_entry_t item_s1;
	logic rowv_s1;
	logic [WAYS-1:0][TAG_W-1:0] tag_rd_s1;
	logic [WAYS-1:0] valid_rd_s1;
	logic [WAYS-1:0][WAY_W-1:0] ord_rd_s1;

	logic [SET_W-1:0] rd_set;
	logic [SET_W-1:0] wr_set;
	logic go;
	logic [WAYS-1:0] valid_eff;
	logic [WAYS-1:0][WAY_W-1:0] ord_eff;
	logic [WAYS-1:0][WAY_W-1:0] ord_up;
	logic [WAYS-1:0][WAY_W-1:0] ord_new;
	logic [WAYS-1:0][TAG_W-1:0] tag_new;
	logic [WAYS-1:0] valid_new;
	logic [WAYS-1:0] match;
	logic hit;
	logic evict;
	logic [WAY_W-1:0] hit_pos;
	logic [WAY_W-1:0] pos;
	logic [WAY_W-1:0] victim;
	logic [CNT_W-1:0] hit_one;
	logic [CNT_W-1:0] hit_next;

	logic res_valid_q;
	logic res_hit_q;
	logic res_evict_q;
	logic res_extra_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] evict_cnt_q;

	assign pop = (state_q == ST_READ) && !empty;
	assign rd_set = head.set[SET_W-1:0];
	assign wr_set = item_s1.set[SET_W-1:0];
	assign go = (state_q == ST_LOOK) && (!res_valid_q || res.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			tag_rd_s1 <= tag_mem[rd_set];
			valid_rd_s1 <= valid_mem[rd_set];
			ord_rd_s1 <= ord_mem[rd_set];
			rowv_s1 <= row_valid_q[rd_set];
			item_s1 <= head;
		end
		if (go) begin
			tag_mem[wr_set] <= tag_new;
			valid_mem[wr_set] <= valid_new;
			ord_mem[wr_set] <= ord_new;
		end
	end

	// A set never written reads as empty with the order in way sequence.
	always_comb begin
		for (int k = 0; k < WAYS; k++) begin
			ord_eff[k] = rowv_s1 ? ord_rd_s1[k] : WAY_W'(k);
			valid_eff[k] = rowv_s1 && valid_rd_s1[k];
		end
		for (int k = 0; k < WAYS; k++)
			match[k] = (LAST_W'(k) <= item_s1.last) && valid_eff[ord_eff[k]]
				&& (tag_rd_s1[ord_eff[k]] == item_s1.tag);
		hit = |match;
		hit_pos = '0;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (match[k])
				hit_pos = WAY_W'(k);
		end
		pos = hit ? hit_pos : '0;
		victim = ord_eff[0];
		evict = !hit && valid_eff[victim];

		ord_up = ord_eff;
		for (int k = 0; k < WAYS - 1; k++)
			ord_up[k] = ord_eff[k + 1];
		// Promote the touched position to the most recent place in use.
		for (int k = 0; k < WAYS; k++) begin
			if (WAY_W'(k) < pos || LAST_W'(k) > item_s1.last)
				ord_new[k] = ord_eff[k];
			else if (LAST_W'(k) == item_s1.last)
				ord_new[k] = ord_eff[pos];
			else
				ord_new[k] = ord_up[k];
		end

		tag_new = tag_rd_s1;
		valid_new = valid_eff;
		if (!hit) begin
			tag_new[victim] = item_s1.tag;
			valid_new[victim] = 1'b1;
		end

		hit_one = hit ? sat_inc(hit_cnt_q) : hit_cnt_q;
		hit_next = item_s1.modify ? sat_inc(hit_one) : hit_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READ;
			row_valid_q <= '0;
			res_valid_q <= 1'b0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			evict_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_READ: begin
					if (pop)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (go)
						state_q <= ST_READ;
				end
				default: state_q <= ST_READ;
			endcase
			if (go) begin
				row_valid_q[wr_set] <= 1'b1;
				res_valid_q <= 1'b1;
				hit_cnt_q <= hit_next;
				if (!hit)
					miss_cnt_q <= sat_inc(miss_cnt_q);
				if (evict)
					evict_cnt_q <= sat_inc(evict_cnt_q);
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_hit_q <= hit;
			res_evict_q <= evict;
			res_extra_q <= item_s1.modify;
		end
	end

	assign res.valid = res_valid_q;
	assign res.was_hit = res_hit_q;
	assign res.was_eviction = res_evict_q;
	assign res.extra_hit = res_extra_q;
	assign res.hit_total = hit_cnt_q;
	assign res.miss_total = miss_cnt_q;
	assign res.eviction_total = evict_cnt_q;

	`SALC_ASSERT_IMP(a_res_from_lookup, $rose(res_valid_q), $past(state_q) == ST_LOOK, "result beat without a lookup")
	`SALC_ASSERT_IMP(a_hit_no_evict, res_valid_q, !(res_hit_q && res_evict_q), "eviction reported on a hit")
	`SALC_ASSERT(a_miss_monotonic, miss_cnt_q >= $past(miss_cnt_q), "miss total went down")
	`SALC_ASSERT_IMP(a_no_pop_in_lookup, state_q == ST_LOOK, !pop, "queue popped during a lookup")

endmodule

// ----- rtl/set_assoc_lru_cache_tag_model.sv -----
// An accepted load, store or modify is queued, its set row is read, and its result beat
// is registered once the result register is free; a fetch is accepted but not queued and
// gives no beat. The back end takes one access at a time, reading its set row from the
// single-port tag store and writing it back; a two-entry queue decouples the input side.
// Reset (arst_n, asynchronous, active low) sets the registers to 4, 4 and 8, clears the
// totals and marks every set empty at once; no clearing pass is needed.
module set_assoc_lru_cache_tag_model #(
	parameter int MAX_SET_BITS = 6,
	parameter int WAYS = 8,
	parameter int ADDR_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [salc_pkg::PADDR_W-1:0] paddr,
	input logic [salc_pkg::PDATA_W-1:0] pwdata,
	output logic [salc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	salc_acc_if.sink acc,
	salc_res_if.source res
);
	import salc_pkg::*;

	q_entry_t push_entry;
	q_entry_t head;
	logic push;
	logic q_full;
	logic pop;
	logic q_empty;

	assign pready = 1'b1;

	salc_front #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.WAYS(WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.acc(acc),
		.q_full(q_full),
		.push(push),
		.entry(push_entry)
	);

	salc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(pop),
		.head(head),
		.empty(q_empty)
	);

	salc_back #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.WAYS(WAYS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(q_empty),
		.pop(pop),
		.res(res)
	);

endmodule
